// ===== sv/rdsm_pkg.sv =====
// Shared types, codes and constants of the dot-star regular expression matcher.
`default_nettype none

package rdsm_pkg;

  // Default size of the token store.
  localparam int unsigned MAX_TOKENS_DEF = 32;

  // Widths of the channel payload fields.
  localparam int unsigned OP_W     = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;

  // Pattern metacharacters.
  localparam logic [BYTE_W-1:0] DOT_BYTE  = 8'h2E;
  localparam logic [BYTE_W-1:0] STAR_BYTE = 8'h2A;

  // Command codes carried in the operation field.
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_START  = 3'd2,
    OP_BYTE   = 3'd3,
    OP_END    = 3'd4
  } op_t;

  // Pattern status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_BAD_STAR = 2'd2
  } status_t;

  // Decoded command strobes, each valid for one processing cycle.
  typedef struct packed {
    logic clear;
    logic append;
    logic start;
    logic step;
    logic finish;
  } cmd_t;

endpackage : rdsm_pkg

`default_nettype wire

// ===== sv/rdsm_in_if.sv =====
// Command channel interface: operation code and byte with valid/ready.
`default_nettype none

interface rdsm_in_if;
  import rdsm_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [BYTE_W-1:0] byte_value;

  modport source (output valid, output operation, output byte_value, input ready);
  modport sink   (input valid, input operation, input byte_value, output ready);

endinterface : rdsm_in_if

`default_nettype wire

// ===== sv/rdsm_out_if.sv =====
// Result channel interface: match flag and pattern status with valid/ready.
`default_nettype none

interface rdsm_out_if;
  import rdsm_pkg::*;

  logic                valid;
  logic                ready;
  logic                matched;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output matched, output status, input ready);
  modport sink   (input valid, input matched, input status, output ready);

endinterface : rdsm_out_if

`default_nettype wire

// ===== sv/rdsm_tokens.sv =====
// Token store: pattern bytes, star flags, token count and sticky pattern status.
`default_nettype none

module rdsm_tokens #(
  parameter int unsigned MAX_TOKENS = rdsm_pkg::MAX_TOKENS_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire rdsm_pkg::cmd_t                            cmd,
  input  wire logic [rdsm_pkg::BYTE_W-1:0]               byte_value,
  output logic [MAX_TOKENS-1:0][rdsm_pkg::BYTE_W-1:0]    tok_bytes,
  output logic [MAX_TOKENS-1:0]                          tok_starred,
  output logic [$clog2(MAX_TOKENS+1)-1:0]                count,
  output rdsm_pkg::status_t                              status
);
  import rdsm_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_TOKENS + 1);
  localparam int unsigned IDX_W = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;

  logic [CNT_W-1:0]      count_next;
  status_t               status_next;
  logic [MAX_TOKENS-1:0] tok_starred_next;
  logic                  byte_we;
  logic                  is_star;
  logic [CNT_W-1:0]      count_dec;
  logic [IDX_W-1:0]      wr_idx;
  logic [IDX_W-1:0]      last_idx;

  assign is_star   = (byte_value == STAR_BYTE);
  assign count_dec = count - CNT_W'(1);
  assign wr_idx    = count[IDX_W-1:0];
  assign last_idx  = count_dec[IDX_W-1:0];

  // Append and clear handling. The first error since the last clear sticks.
  always_comb begin
    count_next       = count;
    status_next      = status;
    tok_starred_next = tok_starred;
    byte_we          = 1'b0;
    if (cmd.clear) begin
      count_next       = '0;
      status_next      = ST_OK;
      tok_starred_next = '0;
    end else if (cmd.append) begin
      if (is_star) begin
        // A star needs a plain token right before it.
        if ((count == '0) || tok_starred[last_idx]) begin
          if (status == ST_OK) begin
            status_next = ST_BAD_STAR;
          end
        end else begin
          tok_starred_next[last_idx] = 1'b1;
        end
      end else if (count == CNT_W'(MAX_TOKENS)) begin
        if (status == ST_OK) begin
          status_next = ST_OVERFLOW;
        end
      end else begin
        tok_starred_next[wr_idx] = 1'b0;
        byte_we                  = 1'b1;
        count_next               = count + CNT_W'(1);
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      status      <= ST_OK;
      tok_starred <= '0;
    end else begin
      count       <= count_next;
      status      <= status_next;
      tok_starred <= tok_starred_next;
    end
  end

  // Pattern bytes are only read below the token count, so they need no reset.
  always_ff @(posedge clk) begin
    if (byte_we) begin
      tok_bytes[wr_idx] <= byte_value;
    end
  end

endmodule : rdsm_tokens

`default_nettype wire

// ===== sv/rdsm_active.sv =====
// Active position set: star closure, one-byte step and the end-of-pattern check.
`default_nettype none

module rdsm_active #(
  parameter int unsigned MAX_TOKENS = rdsm_pkg::MAX_TOKENS_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire rdsm_pkg::cmd_t                            cmd,
  input  wire logic [rdsm_pkg::BYTE_W-1:0]               byte_value,
  input  wire logic [MAX_TOKENS-1:0][rdsm_pkg::BYTE_W-1:0] tok_bytes,
  input  wire logic [MAX_TOKENS-1:0]                     tok_starred,
  input  wire logic [$clog2(MAX_TOKENS+1)-1:0]           count,
  output logic                                           final_hit
);
  import rdsm_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_TOKENS + 1);
  localparam int unsigned LVL   = $clog2(MAX_TOKENS + 1);

  logic [MAX_TOKENS:0]          act;
  logic [MAX_TOKENS:0]          act_next;
  logic [MAX_TOKENS:0]          closed;
  logic [MAX_TOKENS:0]          step_next;
  logic [MAX_TOKENS-1:0]        live;
  logic [MAX_TOKENS-1:0]        hit;
  logic [LVL:0][MAX_TOKENS:0]   gen;
  logic [LVL:0][MAX_TOKENS:0]   prop;

  // A token position is live when it lies below the token count.
  always_comb begin
    for (int i = 0; i < MAX_TOKENS; i++) begin
      live[i] = (count > CNT_W'(i));
    end
  end

  // Star closure is a carry chain: an active position generates, and a
  // live starred token propagates into the position after it. A
  // parallel-prefix network resolves it in log2 levels.
  always_comb begin
    gen[0]     = act;
    prop[0][0] = 1'b0;
    for (int j = 1; j <= MAX_TOKENS; j++) begin
      prop[0][j] = tok_starred[j-1] & live[j-1];
    end
    for (int l = 0; l < LVL; l++) begin
      for (int j = 0; j <= MAX_TOKENS; j++) begin
        if (j >= (1 << l)) begin
          gen[l+1][j]  = gen[l][j] | (prop[l][j] & gen[l][j-(1<<l)]);
          prop[l+1][j] = prop[l][j] & prop[l][j-(1<<l)];
        end else begin
          gen[l+1][j]  = gen[l][j];
          prop[l+1][j] = prop[l][j];
        end
      end
    end
    closed = gen[LVL];
  end

  // One subject byte: a matching starred token stays, a plain one advances.
  always_comb begin
    step_next = '0;
    for (int i = 0; i < MAX_TOKENS; i++) begin
      hit[i] = closed[i] & live[i] &
               ((tok_bytes[i] == DOT_BYTE) || (tok_bytes[i] == byte_value));
      if (tok_starred[i]) begin
        step_next[i]   = step_next[i] | hit[i];
      end else begin
        step_next[i+1] = hit[i];
      end
    end
  end

  // The whole pattern is consumed when the position after the last token is set.
  assign final_hit = closed[count];

  // Next active set.
  always_comb begin
    act_next = act;
    if (cmd.clear || cmd.append || cmd.start) begin
      act_next = (MAX_TOKENS + 1)'(1);
    end else if (cmd.step) begin
      act_next = step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= (MAX_TOKENS + 1)'(1);
    end else begin
      act <= act_next;
    end
  end

endmodule : rdsm_active

`default_nettype wire

// ===== sv/regex_dot_star_matcher.sv =====
// Top level of the dot-star regular expression matcher.
//
// Usage: commands arrive on the cmd channel, one per transfer. Clear empties
// the pattern, append adds one pattern byte ('.' matches any byte, '*' repeats
// the token before it), start begins a subject, byte feeds one subject byte and
// end asks for the verdict. Only end produces a transfer on the result channel,
// carrying matched and the pattern status (ok, overflow, misplaced star).
// A command is captured in the input register at its cmd transfer; a
// non-end command is processed in the following cycle, an end command once the
// result register is free, which then registers its verdict. Throughput is one
// command per cycle while no end command waits for the result register, as the
// closure and step logic covers all token positions combinationally. Reset
// empties the pattern, clears the status, resets the active set to the first
// position and drops any pending result. When the receiver stalls, the result
// stays in its register and non-end commands keep flowing; an end command
// waits in the input register, cmd.ready low, until the result register frees.
`default_nettype none

module regex_dot_star_matcher #(
  parameter int unsigned MAX_TOKENS = rdsm_pkg::MAX_TOKENS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  rdsm_in_if.sink    cmd,
  rdsm_out_if.source result
);
  import rdsm_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_TOKENS + 1);

  logic                               in_valid;
  op_t                                in_op;
  logic [BYTE_W-1:0]                  in_byte;
  logic                               out_free;
  logic                               proc_fire;
  cmd_t                               dec;
  cmd_t                               proc_cmd;
  logic [MAX_TOKENS-1:0][BYTE_W-1:0]  tok_bytes;
  logic [MAX_TOKENS-1:0]              tok_starred;
  logic [CNT_W-1:0]                   count;
  status_t                            status;
  logic                               final_hit;
  logic                               out_valid;
  logic                               out_matched;
  status_t                            out_status;

  // Decode the held command.
  always_comb begin
    dec = '0;
    case (in_op)
      OP_CLEAR:  dec.clear  = 1'b1;
      OP_APPEND: dec.append = 1'b1;
      OP_START:  dec.start  = 1'b1;
      OP_BYTE:   dec.step   = 1'b1;
      OP_END:    dec.finish = 1'b1;
      default:   dec        = '0;
    endcase
  end

  // The held command is processed unless it needs a result slot that is taken.
  assign out_free  = !out_valid || result.ready;
  assign proc_fire = in_valid && (!dec.finish || out_free);
  assign proc_cmd  = proc_fire ? dec : '0;
  assign cmd.ready = !in_valid || proc_fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      in_op   <= op_t'(cmd.operation);
      in_byte <= cmd.byte_value;
    end
  end

  rdsm_tokens #(
    .MAX_TOKENS (MAX_TOKENS)
  ) u_tokens (
    .clk         (clk),
    .rst         (rst),
    .cmd         (proc_cmd),
    .byte_value  (in_byte),
    .tok_bytes   (tok_bytes),
    .tok_starred (tok_starred),
    .count       (count),
    .status      (status)
  );

  rdsm_active #(
    .MAX_TOKENS (MAX_TOKENS)
  ) u_active (
    .clk         (clk),
    .rst         (rst),
    .cmd         (proc_cmd),
    .byte_value  (in_byte),
    .tok_bytes   (tok_bytes),
    .tok_starred (tok_starred),
    .count       (count),
    .final_hit   (final_hit)
  );

  // Result register: loaded by an end command, emptied by a result transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_cmd.finish) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_cmd.finish) begin
      out_matched <= final_hit && (status == ST_OK);
      out_status  <= status;
    end
  end

  assign result.valid   = out_valid;
  assign result.matched = out_matched;
  assign result.status  = out_status;

endmodule : regex_dot_star_matcher

`default_nettype wire
